[rtl/core/depth_pixel_backprojection_defines.svh]
// Assertion macros for the depth pixel back-projection block.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Same-cycle implication under asynchronous active-low reset
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication under asynchronous active-low reset
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/core/dpb_pkg.sv]
// Shared widths, register codes, reset values and pipeline control type
// for the depth pixel back-projection block. No dependencies.
`default_nettype none
package dpb_pkg;

	// Field widths
	localparam int COORD_W  = 12;
	localparam int DEPTH_W  = 16;
	localparam int COLOR_W  = 8;
	localparam int SCALE_W  = 32;
	localparam int CENTER_W = 28;
	localparam int INV_W    = 32;
	localparam int POINT_W  = 32;
	localparam int Z_W      = 31;
	localparam int FRAC_W   = 16;

	// Derived datapath widths
	localparam int ZPROD_W   = DEPTH_W + SCALE_W;          // raw depth times scale
	localparam int DIFF_W    = CENTER_W + 1;               // signed offset from center
	localparam int ZF_PROD_W = Z_W + INV_W;                // z times inverse focal
	localparam int PROD_W    = DIFF_W + Z_W + 1;           // signed offset times z/f
	localparam int SHIFT_W   = PROD_W - FRAC_W;

	// Pipeline depth
	localparam int NUM_STAGES = 5;

	// Default image bounds
	localparam int DPB_MAX_COLUMNS = 4096;
	localparam int DPB_MAX_ROWS    = 4096;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_SCALE = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Y    = 3'd2,
		REG_INV_FOCAL_X = 3'd3,
		REG_INV_FOCAL_Y = 3'd4
	} cfg_reg_t;

	// Register reset values
	localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 32'd858993;
	localparam logic [CENTER_W-1:0] RST_CENTER_X    = 28'd20938752;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 28'd15695872;
	localparam logic [INV_W-1:0]    RST_INV_FOCAL_X = 32'd8181000;
	localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y = 32'd8181000;

	// Per-stage load enables and occupancy
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

endpackage
`default_nettype wire

[rtl/core/dpb_ctrl.sv]
// Valid tracking and per-stage load enables for the back-projection pipeline.
// Depends on dpb_pkg.
`default_nettype none
module dpb_ctrl import dpb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NUM_STAGES-1:0] stage_valid_q;
	logic [NUM_STAGES-1:0] en;

	// A stage loads when it is empty or its content moves on
	always_comb begin
		en[NUM_STAGES-1] = !stage_valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !stage_valid_q[k] || en[k+1];
		end
	end

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = stage_valid_q[NUM_STAGES-1];
	assign ctl.en    = en;
	assign ctl.vld   = stage_valid_q;

endmodule
`default_nettype wire

[rtl/core/dpb_lateral.sv]
// One lateral coordinate: (pos - center) * z / f in Q16.16, saturated.
// Stages 1 to 5 of the pipeline; depends on dpb_pkg.
`default_nettype none
module dpb_lateral import dpb_pkg::*; (
	input  logic                       clk,
	input  pipe_ctl_t                  ctl,
	input  logic [COORD_W-1:0]         pos,
	input  logic [CENTER_W-1:0]        center,
	input  logic [INV_W-1:0]           inv,
	input  logic [Z_W-1:0]             z_s2,
	input  logic                       hit_s4,
	output logic signed [POINT_W-1:0]  coord_s5
);

	logic signed [DIFF_W-1:0]  diff_next;
	logic signed [DIFF_W-1:0]  diff_s1, diff_s2, diff_s3;
	logic [ZF_PROD_W-1:0]      zf_prod_s3;
	logic [Z_W-1:0]            zf;
	logic signed [PROD_W-1:0]  prod_next;
	logic signed [PROD_W-1:0]  prod_s4;
	logic signed [SHIFT_W-1:0] shifted;
	logic [SHIFT_W-POINT_W:0]  upper;
	logic signed [POINT_W-1:0] sat_val;

	// Offset of the pixel from the principal point, signed Q13.16
	assign diff_next = $signed({1'b0, pos, {FRAC_W{1'b0}}})
		- $signed({{(DIFF_W-CENTER_W){1'b0}}, center});

	// z over focal length, Q15.16
	assign zf = zf_prod_s3[ZF_PROD_W-1:INV_W];

	assign prod_next = diff_s3 * $signed({1'b0, zf});

	// Floor shift, then clamp to the signed 32-bit range
	assign shifted = $signed(prod_s4[PROD_W-1:FRAC_W]);
	assign upper   = shifted[SHIFT_W-1:POINT_W-1];

	always_comb begin
		if ((&upper) || !(|upper)) begin
			sat_val = shifted[POINT_W-1:0];
		end else if (shifted[SHIFT_W-1]) begin
			sat_val = {1'b1, {(POINT_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(POINT_W-1){1'b1}}};
		end
	end

	// Pipeline registers, each loads on its own stage enable
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			diff_s1 <= diff_next;
		end
		if (ctl.en[1]) begin
			diff_s2 <= diff_s1;
		end
		if (ctl.en[2]) begin
			diff_s3    <= diff_s2;
			zf_prod_s3 <= z_s2 * inv;
		end
		if (ctl.en[3]) begin
			prod_s4 <= prod_next;
		end
		if (ctl.en[4]) begin
			coord_s5 <= hit_s4 ? sat_val : '0;
		end
	end

endmodule
`default_nettype wire

[rtl/core/depth_pixel_backprojection.sv]
// Depth pixel back-projection top level: config registers, z path, colour.
// Depends on dpb_pkg, dpb_ctrl, dpb_lateral and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one pixel per transaction:
//    column, row, raw depth and an RGB byte triple.
//  - Output channel (out_valid/out_ready) gives one 3-D point per pixel:
//    point_x, point_y (signed Q16.16), point_z (Q15.16), colour bytes and
//    point_valid, in input order.
//  - Config channel (cfg_valid/cfg_ready) writes register cfg_index with
//    cfg_data; it is always ready. Write only while the pipeline is empty.
//  - Stages: 5 register stages (scale multiply, z clamp, z/f multiply,
//    offset multiply, shift and clamp); out_valid rises when a pixel
//    reaches the last stage.
//  - Throughput: one pixel per cycle unless the output stalls; each stage
//    holds one multiply at most, so a new transaction is taken each clock.
//  - Stall: each stage holds while full and the next one is blocked;
//    empty stages keep filling, so in_ready drops only when all 5 are full.
//  - Reset: clears the pipeline valid bits and loads the default camera
//    intrinsics into the registers.
`default_nettype none
`include "depth_pixel_backprojection_defines.svh"
module depth_pixel_backprojection import dpb_pkg::*; #(
	parameter int MAX_COLUMNS = DPB_MAX_COLUMNS,
	parameter int MAX_ROWS    = DPB_MAX_ROWS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	// Pixel input
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_W-1:0]        column,
	input  logic [COORD_W-1:0]        row,
	input  logic [DEPTH_W-1:0]        depth,
	input  logic [COLOR_W-1:0]        red,
	input  logic [COLOR_W-1:0]        green,
	input  logic [COLOR_W-1:0]        blue,
	// Point output
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic [Z_W-1:0]            point_z,
	output logic [COLOR_W-1:0]        out_red,
	output logic [COLOR_W-1:0]        out_green,
	output logic [COLOR_W-1:0]        out_blue,
	output logic                      point_valid
);

	localparam logic [COORD_W:0] COL_LIMIT = (COORD_W+1)'(MAX_COLUMNS);
	localparam logic [COORD_W:0] ROW_LIMIT = (COORD_W+1)'(MAX_ROWS);
	localparam int COLOR3_W = 3 * COLOR_W;

	pipe_ctl_t ctl;

	logic [SCALE_W-1:0]  depth_scale_q;
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [INV_W-1:0]    inv_focal_x_q;
	logic [INV_W-1:0]    inv_focal_y_q;

	logic                inside_next;
	logic [ZPROD_W-1:0]  zprod_s1;
	logic                inside_s1;
	logic [Z_W:0]        zw;
	logic [Z_W-1:0]      z_next;
	logic [Z_W-1:0]      z_s2, z_s3, z_s4, z_s5;
	logic                hit_s2, hit_s3, hit_s4, hit_s5;
	logic [COLOR3_W-1:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic                coords_zero;

	// Register writes; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q <= RST_DEPTH_SCALE;
			center_x_q    <= RST_CENTER_X;
			center_y_q    <= RST_CENTER_Y;
			inv_focal_x_q <= RST_INV_FOCAL_X;
			inv_focal_y_q <= RST_INV_FOCAL_Y;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEPTH_SCALE: depth_scale_q <= cfg_data[SCALE_W-1:0];
				REG_CENTER_X:    center_x_q    <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[CENTER_W-1:0];
				REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data[INV_W-1:0];
				REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data[INV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage valid bits and load enables
	dpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Pixel lies inside the configured image
	assign inside_next = ({1'b0, column} < COL_LIMIT) && ({1'b0, row} < ROW_LIMIT);

	// Drop the fraction of depth*scale and clamp to 31 bits
	assign zw     = zprod_s1[ZPROD_W-1:FRAC_W];
	assign z_next = zw[Z_W] ? {Z_W{1'b1}} : zw[Z_W-1:0];

	// z path, hit flag and colour through the stages
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			zprod_s1  <= depth * depth_scale_q;
			inside_s1 <= inside_next;
			rgb_s1    <= {red, green, blue};
		end
		if (ctl.en[1]) begin
			z_s2   <= z_next;
			hit_s2 <= inside_s1 && (z_next != '0);
			rgb_s2 <= rgb_s1;
		end
		if (ctl.en[2]) begin
			z_s3   <= z_s2;
			hit_s3 <= hit_s2;
			rgb_s3 <= rgb_s2;
		end
		if (ctl.en[3]) begin
			z_s4   <= z_s3;
			hit_s4 <= hit_s3;
			rgb_s4 <= rgb_s3;
		end
		if (ctl.en[4]) begin
			z_s5   <= hit_s4 ? z_s4 : '0;
			hit_s5 <= hit_s4;
			rgb_s5 <= rgb_s4;
		end
	end

	// Lateral coordinates
	dpb_lateral u_lat_x (
		.clk      (clk),
		.ctl      (ctl),
		.pos      (column),
		.center   (center_x_q),
		.inv      (inv_focal_x_q),
		.z_s2     (z_s2),
		.hit_s4   (hit_s4),
		.coord_s5 (point_x)
	);

	dpb_lateral u_lat_y (
		.clk      (clk),
		.ctl      (ctl),
		.pos      (row),
		.center   (center_y_q),
		.inv      (inv_focal_y_q),
		.z_s2     (z_s2),
		.hit_s4   (hit_s4),
		.coord_s5 (point_y)
	);

	assign point_z     = z_s5;
	assign point_valid = hit_s5;
	assign out_red     = rgb_s5[COLOR3_W-1:2*COLOR_W];
	assign out_green   = rgb_s5[2*COLOR_W-1:COLOR_W];
	assign out_blue    = rgb_s5[COLOR_W-1:0];

	// All three coordinates of the output point are zero
	assign coords_zero = (point_x == '0) && (point_y == '0) && (point_z == '0);

	// A point without a hit carries zero coordinates
	`DPB_ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !point_valid, coords_zero)
	// A hit always has a positive depth
	`DPB_ASSERT_IMPL(a_hit_depth, clk, arst_n, out_valid && point_valid, point_z != '0)
	// Input backs up only when every stage is full and the output is blocked
	`DPB_ASSERT_IMPL(a_full_stall, clk, arst_n, !in_ready, (&ctl.vld) && !out_ready)
	// A blocked full pipeline still holds its result next cycle
	`DPB_ASSERT_NEXT(a_hold_full, clk, arst_n, (&ctl.vld) && !out_ready, out_valid)

endmodule
`default_nettype wire

[test/depth_pixel_backprojection_tb.sv]
// Self-checking testbench for depth_pixel_backprojection: pinhole back-projection
// of depth pixels checked against a local fixed-point predictor.
// Depends on dpb_pkg and the depth_pixel_backprojection RTL.
`timescale 1ns / 100ps

module depth_pixel_backprojection_tb;
	import dpb_pkg::*;

	localparam int NUM_REGS     = 5;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RAND_PHASES  = 5;
	localparam int PHASE_ITEMS  = 110;
	localparam logic [Z_W-1:0] Z_LIMIT = {Z_W{1'b1}};
	localparam longint PT_MAX = 64'sd2147483647;
	localparam longint PT_MIN = -64'sd2147483648;

	typedef struct {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_t;

	typedef struct {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic [Z_W-1:0]            z;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
		logic                      valid;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_W-1:0] column = '0;
	logic [COORD_W-1:0] row = '0;
	logic [DEPTH_W-1:0] depth = '0;
	logic [COLOR_W-1:0] red = '0;
	logic [COLOR_W-1:0] green = '0;
	logic [COLOR_W-1:0] blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic [Z_W-1:0] point_z;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_blue;
	logic point_valid;

	// Shadow copy of the camera intrinsics
	logic [SCALE_W-1:0]  depth_scale_r = RST_DEPTH_SCALE;
	logic [CENTER_W-1:0] center_x_r    = RST_CENTER_X;
	logic [CENTER_W-1:0] center_y_r    = RST_CENTER_Y;
	logic [INV_W-1:0]    inv_focal_x_r = RST_INV_FOCAL_X;
	logic [INV_W-1:0]    inv_focal_y_r = RST_INV_FOCAL_Y;

	pixel_t pending_pixels[$];
	point_t expected_points[$];
	pixel_t pixel_on_bus;
	point_t got_point;
	int queued_count = 0;
	int accepted_count = 0;
	int error_count = 0;
	int cycle_count = 0;
	int in_gap = 0;
	int out_gap = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit idle_on = 1'b1;

	depth_pixel_backprojection dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.column      (column),
		.row         (row),
		.depth       (depth),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.point_valid (point_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lateral coordinate: (pos - center) * (z / f), floored and saturated
	function automatic logic signed [POINT_W-1:0] lateral(input logic [COORD_W-1:0] pos,
			input logic [CENTER_W-1:0] center, input logic [Z_W-1:0] z,
			input logic [INV_W-1:0] inv);
		logic [63:0] z_over_f;
		logic signed [63:0] offset;
		logic signed [63:0] prod;
		z_over_f = ({33'd0, z} * {32'd0, inv}) >> INV_W;
		offset = $signed({36'd0, pos, 16'd0}) - $signed({36'd0, center});
		prod = (offset * $signed(z_over_f)) >>> FRAC_W;
		if (prod > PT_MAX)
			return PT_MAX[POINT_W-1:0];
		if (prod < PT_MIN)
			return PT_MIN[POINT_W-1:0];
		return prod[POINT_W-1:0];
	endfunction

	function automatic point_t backproject(input pixel_t px);
		point_t pt;
		logic [47:0] z_wide;
		logic [Z_W-1:0] z;
		z_wide = ({32'd0, px.depth} * {16'd0, depth_scale_r}) >> FRAC_W;
		z = (z_wide > {17'd0, Z_LIMIT}) ? Z_LIMIT : z_wide[Z_W-1:0];
		pt.red = px.red;
		pt.green = px.green;
		pt.blue = px.blue;
		if (px.column < DPB_MAX_COLUMNS && px.row < DPB_MAX_ROWS && z != '0) begin
			pt.x = lateral(px.column, center_x_r, z, inv_focal_x_r);
			pt.y = lateral(px.row, center_y_r, z, inv_focal_y_r);
			pt.z = z;
			pt.valid = 1'b1;
		end else begin
			pt.x = '0;
			pt.y = '0;
			pt.z = '0;
			pt.valid = 1'b0;
		end
		return pt;
	endfunction

	function automatic pixel_t make_pixel(input int c, input int r, input int d,
			input int rd, input int gr, input int bl);
		pixel_t px;
		px.column = COORD_W'(c);
		px.row = COORD_W'(r);
		px.depth = DEPTH_W'(d);
		px.red = COLOR_W'(rd);
		px.green = COLOR_W'(gr);
		px.blue = COLOR_W'(bl);
		return px;
	endfunction

	// Mostly full-range depth, with a share of missing and tiny samples
	function automatic pixel_t rand_pixel();
		pixel_t px;
		int pick;
		pick = $urandom_range(0, 7);
		px.column = COORD_W'($urandom_range(0, 4095));
		px.row = COORD_W'($urandom_range(0, 4095));
		if (pick == 0)
			px.depth = '0;
		else if (pick == 1)
			px.depth = DEPTH_W'($urandom_range(1, 64));
		else
			px.depth = DEPTH_W'($urandom_range(0, 65535));
		px.red = COLOR_W'($urandom_range(0, 255));
		px.green = COLOR_W'($urandom_range(0, 255));
		px.blue = COLOR_W'($urandom_range(0, 255));
		return px;
	endfunction

	task automatic queue_pixel(input pixel_t px);
		pending_pixels = {pending_pixels, px};
		queued_count++;
	endtask

	// Write one register and mirror it into the shadow copy on the transaction
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_DEPTH_SCALE: depth_scale_r = data[SCALE_W-1:0];
			REG_CENTER_X:    center_x_r = data[CENTER_W-1:0];
			REG_CENTER_Y:    center_y_r = data[CENTER_W-1:0];
			REG_INV_FOCAL_X: inv_focal_x_r = data[INV_W-1:0];
			REG_INV_FOCAL_Y: inv_focal_y_r = data[INV_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued pixel is through and the pipeline is empty
	task automatic drain();
		while (accepted_count != queued_count || expected_points.size() != 0)
			@(posedge clk);
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// Realistic intrinsics, fully random words, or register extremes
	task automatic random_config(input int kind);
		logic [CFG_DATA_W-1:0] v [NUM_REGS];
		for (int i = 0; i < NUM_REGS; i++) begin
			if (kind == 0)
				v[i] = (i == 1 || i == 2) ? $urandom_range(0, 4095 << FRAC_W) :
					$urandom_range(100000, 20000000);
			else if (kind == 1)
				v[i] = $urandom();
			else
				v[i] = $urandom_range(0, 1) ? '1 : '0;
		end
		cfg_write(REG_DEPTH_SCALE, v[0]);
		cfg_write(REG_CENTER_X, v[1]);
		cfg_write(REG_CENTER_Y, v[2]);
		cfg_write(REG_INV_FOCAL_X, v[3]);
		cfg_write(REG_INV_FOCAL_Y, v[4]);
	endtask

	task automatic field_check(input string label, input logic [POINT_W-1:0] want,
			input logic [POINT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch expected %h actual %h", $realtime, label, want, got);
			error_count++;
		end
	endtask

	// Drive pixels: record each transaction, then present the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_points = {expected_points, backproject(pixel_on_bus)};
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					pixel_on_bus = pending_pixels.pop_front();
					column <= pixel_on_bus.column;
					row <= pixel_on_bus.row;
					depth <= pixel_on_bus.depth;
					red <= pixel_on_bus.red;
					green <= pixel_on_bus.green;
					blue <= pixel_on_bus.blue;
					in_valid <= 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0)
						in_gap = $urandom_range(1, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check points against the oldest prediction and pace out_ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: point with no pending pixel, actual x %h y %h z %h",
						$realtime, point_x, point_y, point_z);
					error_count++;
				end else begin
					got_point = expected_points.pop_front();
					field_check("point_x", got_point.x, point_x);
					field_check("point_y", got_point.y, point_y);
					field_check("point_z", {1'b0, got_point.z}, {1'b0, point_z});
					field_check("out_red", {24'd0, got_point.red}, {24'd0, out_red});
					field_check("out_green", {24'd0, got_point.green}, {24'd0, out_green});
					field_check("out_blue", {24'd0, got_point.blue}, {24'd0, out_blue});
					field_check("point_valid", {31'd0, got_point.valid}, {31'd0, point_valid});
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0)
					out_gap = $urandom_range(1, 11);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset intrinsics: blank pixel, full-scale pixel, tiny depth, principal point
		queue_pixel(make_pixel(0, 0, 0, 0, 0, 0));
		queue_pixel(make_pixel(4095, 4095, 65535, 255, 255, 255));
		queue_pixel(make_pixel(1, 2, 1, 'hAA, 'h55, 'hAA));
		queue_pixel(make_pixel(319, 239, 1000, 'h55, 'hAA, 'h55));
		queue_pixel(make_pixel(320, 240, 1000, 'h0F, 'hF0, 'h3C));
		drain();

		// Saturating z and both lateral extremes; center y gets bits above its width
		cfg_write(REG_DEPTH_SCALE, '1);
		cfg_write(REG_CENTER_X, '0);
		cfg_write(REG_CENTER_Y, '1);
		cfg_write(REG_INV_FOCAL_X, '1);
		cfg_write(REG_INV_FOCAL_Y, '1);
		for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), $urandom());
		queue_pixel(make_pixel(4095, 0, 65535, 1, 2, 3));
		queue_pixel(make_pixel(0, 4095, 65535, 4, 5, 6));
		queue_pixel(make_pixel(0, 0, 1, 7, 8, 9));
		queue_pixel(make_pixel(4095, 4095, 300, 10, 11, 12));
		drain();

		// Depth that truncates to zero, and a zero inverse focal length
		cfg_write(REG_DEPTH_SCALE, 1);
		cfg_write(REG_INV_FOCAL_X, '0);
		cfg_write(REG_INV_FOCAL_Y, 1);
		cfg_write(REG_CENTER_X, RST_CENTER_X);
		queue_pixel(make_pixel(100, 200, 65535, 13, 14, 15));
		drain();
		cfg_write(REG_DEPTH_SCALE, 1 << 20);
		queue_pixel(make_pixel(100, 200, 65535, 16, 17, 18));
		drain();

		// Zero scale kills every point
		cfg_write(REG_DEPTH_SCALE, '0);
		queue_pixel(make_pixel(4095, 4095, 65535, 19, 20, 21));
		drain();

		// Random phases; one long output stall, and no idling in the last phase
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_config(ph % 3);
			if (ph == RAND_PHASES - 1) begin
				idle_on = 1'b0;
				in_gap = 0;
				out_gap = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_pixel(rand_pixel());
			if (ph == 2)
				hold_req = 1'b1;
			drain();
		end

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
